>>> rtl/core/frontier_state_cell_step_top_defines.svh
// Assertion macros used by the frontier step top module.
`ifndef FRONTIER_STATE_CELL_STEP_TOP_DEFINES_SVH
`define FRONTIER_STATE_CELL_STEP_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FSCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frontier step check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FSCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frontier step check failed");

`endif

>>> rtl/core/fscs_pkg.sv
package fscs_pkg;

  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned NUM_SLOTS = 14;
  localparam int unsigned WORD_W    = SLOT_W * NUM_SLOTS;
  localparam int unsigned WEIGHT_W  = 64;
  localparam int unsigned COORD_W   = 4;
  localparam int unsigned GRID_W    = 4;

  localparam logic [SLOT_W-1:0] SLOT_DEFECT = 4'd14;
  localparam logic [SLOT_W-1:0] SLOT_EMPTY  = 4'd15;

  localparam logic [GRID_W-1:0] GRID_RESET = 4'd9;
  localparam logic [GRID_W-1:0] GRID_MIN   = 4'd1;
  localparam logic [GRID_W-1:0] GRID_MAX   = 4'd13;

  typedef enum logic [0:0] {
    REQ_CELL    = 1'b0,
    REQ_REINDEX = 1'b1
  } req_e;

  // One request as held in the input register.
  typedef struct packed {
    req_e                  req_type;
    logic [COORD_W-1:0]    column;
    logic [COORD_W-1:0]    row;
    logic [WORD_W-1:0]     slot_word;
  } step_req_t;

  // Successors of one request: count (0..2) and the two candidate words.
  typedef struct packed {
    logic [1:0]            cnt;
    logic [WORD_W-1:0]     word0;
    logic [WORD_W-1:0]     word1;
  } step_res_t;

  // Reads one slot; an index beyond the word reads as empty.
  function automatic logic [SLOT_W-1:0] slot_get(input logic [WORD_W-1:0] w,
                                                 input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] v;
    v = SLOT_EMPTY;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (idx == SLOT_W'(i)) v = w[SLOT_W*i +: SLOT_W];
    end
    return v;
  endfunction

  // Writes one slot; an index beyond the word leaves it unchanged.
  function automatic logic [WORD_W-1:0] slot_put(input logic [WORD_W-1:0] w,
                                                 input logic [SLOT_W-1:0] idx,
                                                 input logic [SLOT_W-1:0] val);
    logic [WORD_W-1:0] r;
    r = w;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (idx == SLOT_W'(i)) r[SLOT_W*i +: SLOT_W] = val;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/frontier_state_cell_step_top.sv
// Requests are held in the input register, results in the single output register.
// Throughput: one request per cycle when it yields a single result and the output
// is not stalled; a request with two results is held until both have been emitted.
// Reset: grid_size returns to 9, input and output stages are emptied.
`include "frontier_state_cell_step_top_defines.svh"

module frontier_state_cell_step_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write: grid_size.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fscs_pkg::GRID_W-1:0]   cfg_data_i,
  // Request stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,  // column, row, slot_word, weight
  input  logic                          s_axis_tuser,  // req_type
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [119:0]                  m_axis_tdata,  // next_word, weight_out
  output logic                          m_axis_tuser,  // keep
  output logic                          m_axis_tlast   // last
);

  logic [fscs_pkg::GRID_W-1:0]   grid_q;
  logic                          in_valid_q, in_valid_d;
  logic                          in_second_q, in_second_d;
  fscs_pkg::step_req_t           in_req_q;
  logic [fscs_pkg::WEIGHT_W-1:0] in_weight_q;
  fscs_pkg::step_res_t           res;
  logic                          out_valid_q, out_valid_d;
  logic [fscs_pkg::WORD_W-1:0]   out_word_q, out_word_d;
  logic [fscs_pkg::WEIGHT_W-1:0] out_weight_q, out_weight_d;
  logic                          out_keep_q, out_keep_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free, emit, single, in_done, in_accept;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= fscs_pkg::GRID_RESET;
    end else if (cfg_valid_i) begin
      grid_q <= cfg_data_i;
    end
  end

  // Successor logic on the held request.
  fscs_step u_step (
    .grid_i (grid_q),
    .req_i  (in_req_q),
    .res_o  (res)
  );

  // Hand-off control between input stage and output register.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit          = in_valid_q && out_free;
  assign single        = (res.cnt != 2'd2);
  assign in_done       = emit && (single || in_second_q);
  assign s_axis_tready = !in_valid_q || in_done;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d  = in_valid_q;
    in_second_d = in_second_q;
    if (in_accept) begin
      in_valid_d  = 1'b1;
      in_second_d = 1'b0;
    end else if (in_done) begin
      in_valid_d  = 1'b0;
      in_second_d = 1'b0;
    end else if (emit) begin
      in_second_d = 1'b1;
    end
  end

  // Next contents of the output register.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    out_weight_d = out_weight_q;
    out_keep_d   = out_keep_q;
    out_last_d   = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      if (res.cnt == 2'd0) begin
        out_word_d   = '0;
        out_weight_d = '0;
        out_keep_d   = 1'b0;
      end else begin
        out_word_d   = in_second_q ? res.word1 : res.word0;
        out_weight_d = in_weight_q;
        out_keep_d   = 1'b1;
      end
      out_last_d = single || in_second_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_second_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      in_second_q <= in_second_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q.req_type  <= fscs_pkg::req_e'(s_axis_tuser);
      in_req_q.column    <= s_axis_tdata[3:0];
      in_req_q.row       <= s_axis_tdata[7:4];
      in_req_q.slot_word <= s_axis_tdata[63:8];
      in_weight_q        <= s_axis_tdata[127:64];
    end
    out_word_q   <= out_word_d;
    out_weight_q <= out_weight_d;
    out_keep_q   <= out_keep_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_weight_q, out_word_q};
  assign m_axis_tuser  = out_keep_q;
  assign m_axis_tlast  = out_last_q;

  // A pruned request always yields exactly one, final, result.
  `FSCS_ASSERT_NOW(a_prune_is_last, out_valid_q && !out_keep_q, out_last_q)
  // The second result is only pending while its request is still held.
  `FSCS_ASSERT_NOW(a_second_held, in_second_q, in_valid_q)
  // A non-final result waiting at the output keeps its request in the input stage.
  `FSCS_ASSERT_NOW(a_first_keeps_req, out_valid_q && !out_last_q, in_valid_q && in_second_q)
  // Emitting the first of two results leaves the request waiting for its second.
  `FSCS_ASSERT_NEXT(a_first_then_second, emit && !single && !in_second_q, in_second_q)

endmodule

>>> rtl/core/fscs_step.sv
// Combinational successor logic for one frontier request.
module fscs_step (
  input  logic [fscs_pkg::GRID_W-1:0] grid_i,
  input  fscs_pkg::step_req_t         req_i,
  output fscs_pkg::step_res_t         res_o
);

  // Moves one arc end to slot pos; a defect end carries no partner to update.
  function automatic logic [fscs_pkg::WORD_W-1:0] move_end(
      input logic [fscs_pkg::WORD_W-1:0] base,
      input logic [fscs_pkg::SLOT_W-1:0] label,
      input logic [fscs_pkg::SLOT_W-1:0] pos);
    logic [fscs_pkg::WORD_W-1:0] r;
    if (label == fscs_pkg::SLOT_DEFECT) begin
      r = fscs_pkg::slot_put(base, pos, fscs_pkg::SLOT_DEFECT);
    end else begin
      r = fscs_pkg::slot_put(base, pos, label);
      r = fscs_pkg::slot_put(r, label, pos);
    end
    return r;
  endfunction

  logic [fscs_pkg::GRID_W-1:0]    n;
  logic [fscs_pkg::SLOT_W-1:0]    p, q, a, b, lbl, other, v;
  logic [fscs_pkg::NUM_SLOTS-1:0] used;
  logic                           any_used, one_used;
  logic                           is_src, is_tgt, down, right;
  logic [1:0]                     ends;
  logic [fscs_pkg::WORD_W-1:0]    w, base, w_down, w_right, shifted;

  always_comb begin
    res_o = '0;

    // Out-of-range grid sizes are clamped.
    if (grid_i < fscs_pkg::GRID_MIN) begin
      n = fscs_pkg::GRID_MIN;
    end else if (grid_i > fscs_pkg::GRID_MAX) begin
      n = fscs_pkg::GRID_MAX;
    end else begin
      n = grid_i;
    end

    w = req_i.slot_word;
    p = req_i.column;
    q = req_i.column + 4'd1;
    a = fscs_pkg::slot_get(w, p);
    b = fscs_pkg::slot_get(w, q);

    // Occupancy of the slots in use, 0 to n.
    for (int i = 0; i < fscs_pkg::NUM_SLOTS; i++) begin
      used[i] = (w[fscs_pkg::SLOT_W*i +: fscs_pkg::SLOT_W] != fscs_pkg::SLOT_EMPTY) &&
                (fscs_pkg::SLOT_W'(i) <= n);
    end
    any_used = |used;
    one_used = any_used &&
               ((used & (used - fscs_pkg::NUM_SLOTS'(1))) == '0);

    is_src = (req_i.column == '0) && (req_i.row == '0);
    is_tgt = (q == n) && ((req_i.row + 4'd1) == n);
    down   = (req_i.row + 4'd1) < n;
    right  = q < n;
    ends   = {1'b0, a != fscs_pkg::SLOT_EMPTY} + {1'b0, b != fscs_pkg::SLOT_EMPTY};
    lbl    = (a != fscs_pkg::SLOT_EMPTY) ? a : b;
    other  = (a == fscs_pkg::SLOT_DEFECT) ? b : a;

    base = fscs_pkg::slot_put(fscs_pkg::slot_put(w, p, fscs_pkg::SLOT_EMPTY), q,
                              fscs_pkg::SLOT_EMPTY);

    // Reindex: slot j takes slot j-1 with its partner index raised by one.
    shifted = '0;
    for (int j = 0; j < fscs_pkg::NUM_SLOTS; j++) begin
      v = '0;
      if (j == 0) begin
        v = fscs_pkg::SLOT_EMPTY;
      end else if (fscs_pkg::SLOT_W'(j) <= n) begin
        v = w[fscs_pkg::SLOT_W*(j-1) +: fscs_pkg::SLOT_W];
        if (v != fscs_pkg::SLOT_EMPTY && v != fscs_pkg::SLOT_DEFECT) v = v + 4'd1;
      end
      shifted[fscs_pkg::SLOT_W*j +: fscs_pkg::SLOT_W] = v;
    end

    // Candidate words for the downward and rightward moves.
    w_down  = base;
    w_right = base;
    if (is_src) begin
      w_down  = fscs_pkg::slot_put(w, p, fscs_pkg::SLOT_DEFECT);
      w_right = fscs_pkg::slot_put(w, q, fscs_pkg::SLOT_DEFECT);
    end else if (ends == 2'd0) begin
      w_right = fscs_pkg::slot_put(fscs_pkg::slot_put(base, p, q), q, p);
    end else begin
      w_down  = move_end(base, lbl, p);
      w_right = move_end(base, lbl, q);
    end

    if (req_i.req_type == fscs_pkg::REQ_REINDEX) begin
      if (fscs_pkg::slot_get(w, n) == fscs_pkg::SLOT_EMPTY) begin
        res_o.cnt   = 2'd1;
        res_o.word0 = shifted;
      end
    end else if (req_i.column < n && req_i.row < n) begin
      if (is_src) begin
        // Source cell: the frontier must be empty; the defect starts here.
        if (!any_used) begin
          res_o.cnt   = {1'b0, down} + {1'b0, right};
          res_o.word0 = down ? w_down : w_right;
          res_o.word1 = w_right;
        end
      end else if (is_tgt) begin
        // Target cell: only the defect end may remain and it must arrive here.
        if (one_used && ends == 2'd1 && lbl == fscs_pkg::SLOT_DEFECT) begin
          res_o.cnt   = 2'd1;
          res_o.word0 = base;
        end
      end else if (ends == 2'd0) begin
        // Skip first, then open a new arc when both directions exist.
        res_o.cnt   = (down && right) ? 2'd2 : 2'd1;
        res_o.word0 = base;
        res_o.word1 = w_right;
      end else if (ends == 2'd1) begin
        res_o.cnt   = {1'b0, down} + {1'b0, right};
        res_o.word0 = down ? w_down : w_right;
        res_o.word1 = w_right;
      end else begin
        // Two ends meet: join them unless that would close a loop.
        if (!(a == q && b == p)) begin
          if (a == fscs_pkg::SLOT_DEFECT || b == fscs_pkg::SLOT_DEFECT) begin
            if (other != fscs_pkg::SLOT_EMPTY && other != fscs_pkg::SLOT_DEFECT) begin
              res_o.cnt   = 2'd1;
              res_o.word0 = fscs_pkg::slot_put(base, other, fscs_pkg::SLOT_DEFECT);
            end
          end else begin
            res_o.cnt   = 2'd1;
            res_o.word0 = fscs_pkg::slot_put(fscs_pkg::slot_put(base, a, b), b, a);
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_top.sv
module tb_top;
  import fscs_pkg::*;

  localparam int PLAN_LEN   = 25;
  localparam int PHASES     = 9;
  localparam int PHASE_REQS = 117;
  localparam logic [WORD_W-1:0] ALL_EMPTY = '1;
  localparam logic [GRID_W-1:0] PHASE_GRIDS [PHASES] =
    '{4'd13, 4'd2, 4'd9, 4'd1, 4'd6, 4'd14, 4'd3, 4'd11, 4'd0};

  // One successor as it should leave the block.
  typedef struct packed {
    logic [WORD_W-1:0]   word;
    logic [WEIGHT_W-1:0] wt;
    logic                keep;
    logic                last;
  } succ_rec_t;

  // One directed request; typed rows carry their single result by hand.
  typedef struct {
    logic [GRID_W-1:0]   grid;
    req_e                kind;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic [WORD_W-1:0]   word;
    logic [WEIGHT_W-1:0] wt;
    bit                  typed;
    logic [WORD_W-1:0]   exp_word;
    bit                  exp_keep;
  } step_plan_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [GRID_W-1:0]   cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [127:0]        s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [119:0]        m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  // Hand-typed expectation travelling alongside the request on the bus.
  logic                hint_on       = 1'b0;
  logic [WORD_W-1:0]   hint_word     = '0;
  logic                hint_keep     = 1'b0;

  logic [GRID_W-1:0]   grid_cfg      = GRID_RESET;
  int                  snd_idle_pct  = 0;
  int                  rcv_idle_pct  = 0;
  int                  mismatch_cnt  = 0;
  succ_rec_t           pending_successors [$];
  step_plan_t          plan [PLAN_LEN];

  frontier_state_cell_step_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Slot access; indexes past the word read as empty and ignore writes.
  function automatic logic [SLOT_W-1:0] nib(input logic [WORD_W-1:0] w, input int i);
    if (i >= NUM_SLOTS) return SLOT_EMPTY;
    return w[SLOT_W*i +: SLOT_W];
  endfunction

  function automatic logic [WORD_W-1:0] with_nib(input logic [WORD_W-1:0] w, input int i,
                                                 input logic [SLOT_W-1:0] v);
    logic [WORD_W-1:0] r;
    r = w;
    if (i < NUM_SLOTS) r[SLOT_W*i +: SLOT_W] = v;
    return r;
  endfunction

  // Moves one arc end to slot pos and points its partner back at it.
  function automatic logic [WORD_W-1:0] carry_end(input logic [WORD_W-1:0] base,
                                                  input logic [SLOT_W-1:0] label, input int pos);
    if (label == SLOT_DEFECT) return with_nib(base, pos, SLOT_DEFECT);
    return with_nib(with_nib(base, pos, label), label, SLOT_W'(pos));
  endfunction

  // Successor states of one request; returns how many there are (0 = pruned).
  function automatic int successor_states(input logic [GRID_W-1:0] grid, input req_e kind,
                                          input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row,
                                          input logic [WORD_W-1:0] word,
                                          output logic [1:0][WORD_W-1:0] nxt);
    int n, x, y, k, used, ends;
    logic [SLOT_W-1:0] a, b, v, other;
    logic [WORD_W-1:0] base, z;
    bit down, right, src, tgt;
    nxt = '0;
    n = grid;
    if (n < GRID_MIN) n = GRID_MIN;
    if (n > GRID_MAX) n = GRID_MAX;

    // Row shift: every slot moves up by one and partner indexes follow.
    if (kind == REQ_REINDEX) begin
      if (nib(word, n) != SLOT_EMPTY) return 0;
      z = '0;
      for (int i = 0; i <= n; i++) z = with_nib(z, i, SLOT_EMPTY);
      for (int i = 0; i < n; i++) begin
        v = nib(word, i);
        if (v == SLOT_DEFECT) z = with_nib(z, i + 1, SLOT_DEFECT);
        else if (v != SLOT_EMPTY) z = with_nib(z, i + 1, v + 4'd1);
      end
      nxt[0] = z;
      return 1;
    end

    x = col;
    y = row;
    if (x >= n || y >= n) return 0;
    used = 0;
    for (int i = 0; i <= n; i++) used += (nib(word, i) != SLOT_EMPTY);
    a     = nib(word, x);
    b     = nib(word, x + 1);
    ends  = (a != SLOT_EMPTY) + (b != SLOT_EMPTY);
    src   = (x == 0 && y == 0);
    tgt   = (x + 1 == n && y + 1 == n);
    down  = (y + 1 < n);
    right = (x + 1 < n);
    k     = 0;

    // The source cell starts the defect line from an empty frontier.
    if (src) begin
      if (used != 0) return 0;
      if (down) begin
        nxt[k] = with_nib(word, x, SLOT_DEFECT);
        k++;
      end
      if (right) begin
        nxt[k] = with_nib(word, x + 1, SLOT_DEFECT);
        k++;
      end
      return k;
    end

    base = with_nib(with_nib(word, x, SLOT_EMPTY), x + 1, SLOT_EMPTY);

    // The target cell takes only the lone defect end.
    if (tgt) begin
      v = (a != SLOT_EMPTY) ? a : b;
      if (used != 1 || ends != 1 || v != SLOT_DEFECT) return 0;
      nxt[0] = base;
      return 1;
    end

    if (ends == 0) begin
      nxt[0] = base;
      k = 1;
      if (down && right) begin
        nxt[1] = with_nib(with_nib(base, x, SLOT_W'(x + 1)), x + 1, SLOT_W'(x));
        k = 2;
      end
    end else if (ends == 1) begin
      v = (a != SLOT_EMPTY) ? a : b;
      if (down) begin
        nxt[k] = carry_end(base, v, x);
        k++;
      end
      if (right) begin
        nxt[k] = carry_end(base, v, x + 1);
        k++;
      end
    end else begin
      // Two ends meet: a closed loop is pruned, otherwise the far ends join.
      if (a == SLOT_W'(x + 1) && b == SLOT_W'(x)) return 0;
      if (a == SLOT_DEFECT || b == SLOT_DEFECT) begin
        other = (a == SLOT_DEFECT) ? b : a;
        if (other == SLOT_EMPTY || other == SLOT_DEFECT) return 0;
        nxt[0] = with_nib(base, other, SLOT_DEFECT);
      end else begin
        nxt[0] = with_nib(with_nib(base, a, b), b, a);
      end
      k = 1;
    end
    return k;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // Result side stalls at random.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Predict on each accepted request, then check each accepted result in order.
  always @(posedge clk_i) begin : successor_check
    int cnt;
    logic [1:0][WORD_W-1:0] nxt;
    succ_rec_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (hint_on) begin
          if (hint_keep) pending_successors.push_back('{hint_word, s_axis_tdata[127:64], 1'b1, 1'b1});
          else pending_successors.push_back('{'0, '0, 1'b0, 1'b1});
        end else begin
          cnt = successor_states(grid_cfg, req_e'(s_axis_tuser), s_axis_tdata[3:0],
                                 s_axis_tdata[7:4], s_axis_tdata[63:8], nxt);
          if (cnt == 0) pending_successors.push_back('{'0, '0, 1'b0, 1'b1});
          for (int k = 0; k < cnt; k++)
            pending_successors.push_back('{nxt[k], s_axis_tdata[127:64], 1'b1, 1'(k == cnt - 1)});
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_successors.size() == 0) begin
          $error("result with no request outstanding: next_word %h", m_axis_tdata[55:0]);
          mismatch_cnt++;
        end else begin
          want = pending_successors.pop_front();
          check_field("next_word", 64'(want.word), 64'(m_axis_tdata[55:0]));
          check_field("weight_out", want.wt, m_axis_tdata[119:56]);
          check_field("keep", 64'(want.keep), 64'(m_axis_tuser));
          check_field("last", 64'(want.last), 64'(m_axis_tlast));
        end
      end
    end
  end

  // Presents one request after a random gap and holds it until it is taken.
  task automatic send_request(input req_e kind, input logic [COORD_W-1:0] col,
                              input logic [COORD_W-1:0] row, input logic [WORD_W-1:0] word,
                              input logic [WEIGHT_W-1:0] wt, input bit typed,
                              input logic [WORD_W-1:0] exp_word, input bit exp_keep);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wt, word, row, col};
    s_axis_tuser  <= kind;
    hint_on       <= typed;
    hint_word     <= exp_word;
    hint_keep     <= exp_keep;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_successors.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic program_grid(input logic [GRID_W-1:0] v);
    settle_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    grid_cfg = v;
  endtask

  // Mostly well-formed frontiers with random pairing; some pure noise.
  task automatic send_random_item();
    int n, x, y, i, j, r, spot;
    logic [WORD_W-1:0] w;
    logic [WEIGHT_W-1:0] wt;
    req_e kind;
    bit have_defect;
    n = grid_cfg;
    if (n < GRID_MIN) n = GRID_MIN;
    if (n > GRID_MAX) n = GRID_MAX;
    wt = {$urandom, $urandom};
    w  = ALL_EMPTY;
    r  = $urandom_range(99);
    if (r < 12) begin
      kind = req_e'($urandom_range(1));
      x    = $urandom_range(15);
      y    = $urandom_range(15);
      w    = WORD_W'({$urandom, $urandom});
    end else begin
      kind = ($urandom_range(99) < 15) ? REQ_REINDEX : REQ_CELL;
      x    = $urandom_range(n - 1);
      y    = $urandom_range(n - 1);
      r    = $urandom_range(99);
      if (r < 10) begin
        x = 0;
        y = 0;
      end else if (r < 20) begin
        x = n - 1;
        y = n - 1;
      end
      // Slots beyond the grid carry junk that cell requests must pass through.
      if ($urandom_range(1))
        for (i = n + 1; i < NUM_SLOTS; i++) w[SLOT_W*i +: SLOT_W] = SLOT_W'($urandom_range(15));
      r = $urandom_range(99);
      if (r >= 20 && r < 35) begin
        spot = $urandom_range(1) ? x + $urandom_range(1) : $urandom_range(n);
        w[SLOT_W*spot +: SLOT_W] = SLOT_DEFECT;
      end else if (r >= 35) begin
        have_defect = 1'b0;
        if ($urandom_range(3) == 0) begin
          w[SLOT_W*x +: SLOT_W]       = SLOT_W'(x + 1);
          w[SLOT_W*(x + 1) +: SLOT_W] = SLOT_W'(x);
        end
        for (i = 0; i <= n; i++) begin
          if (w[SLOT_W*i +: SLOT_W] == SLOT_EMPTY && $urandom_range(99) < 45) begin
            if (!have_defect && $urandom_range(4) == 0) begin
              w[SLOT_W*i +: SLOT_W] = SLOT_DEFECT;
              have_defect = 1'b1;
            end else if (i < n) begin
              for (int t = 0; t < 4; t++) begin
                j = $urandom_range(n, i + 1);
                if (w[SLOT_W*j +: SLOT_W] == SLOT_EMPTY) begin
                  w[SLOT_W*i +: SLOT_W] = SLOT_W'(j);
                  w[SLOT_W*j +: SLOT_W] = SLOT_W'(i);
                  break;
                end
              end
            end
          end
        end
      end
      if (kind == REQ_REINDEX && $urandom_range(99) < 70) w[SLOT_W*n +: SLOT_W] = SLOT_EMPTY;
    end
    send_request(kind, COORD_W'(x), COORD_W'(y), w, wt, 1'b0, '0, 1'b0);
  endtask

  initial begin
    plan = '{
      // Reset size 9: off-grid column and row.
      '{4'd9, REQ_CELL, 4'd9, 4'd0, ALL_EMPTY, 64'h0123_4567_89AB_CDEF, 1, '0, 0},
      '{4'd9, REQ_CELL, 4'd0, 4'd9, ALL_EMPTY, 64'hFFFF_FFFF_FFFF_FFFF, 1, '0, 0},
      // Source cell, clean and dirty.
      '{4'd9, REQ_CELL, 4'd0, 4'd0, ALL_EMPTY, 64'hFFFF_FFFF_FFFF_FFFF, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd0, 4'd0, 56'hFFFFFFFFFFFFF0, 64'h8000_0000_0000_0001, 1, '0, 0},
      // Target cell with the defect alone, then with company.
      '{4'd9, REQ_CELL, 4'd8, 4'd8, 56'hFFFFFEFFFFFFFF, 64'h0, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd8, 4'd8, 56'hFFFFFEFFFFFFFE, 64'h5555_AAAA_5555_AAAA, 1, '0, 0},
      // No ends: skip and cup, and skip only at the right edge.
      '{4'd9, REQ_CELL, 4'd3, 4'd2, ALL_EMPTY, 64'hDEAD_BEEF_0000_0001, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd8, 4'd2, ALL_EMPTY, 64'h1, 0, '0, 0},
      // One end: an arc on the bottom row, a defect mid-grid.
      '{4'd9, REQ_CELL, 4'd3, 4'd8, 56'hFFFFFF3FFF7FFF, 64'h7FFF_FFFF_FFFF_FFFF, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd3, 4'd2, 56'hFFFFFFFFFEFFFF, 64'h2, 0, '0, 0},
      // Two ends: closed loop, defect with arc, two arcs, two defects.
      '{4'd9, REQ_CELL, 4'd3, 4'd2, 56'hFFFFFFFFF34FFF, 64'h3, 1, '0, 0},
      '{4'd9, REQ_CELL, 4'd3, 4'd2, 56'hFFFFFFF4F6EFFF, 64'h4, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd3, 4'd2, 56'hFFFF4FFFF90FF3, 64'h5, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd3, 4'd2, 56'hFFFFFFFFFEEFFF, 64'h6, 1, '0, 0},
      // Row shift: empty, top slot in use, mixed with junk above the grid.
      '{4'd9, REQ_REINDEX, 4'd15, 4'd15, ALL_EMPTY, 64'hFFFF_FFFF_FFFF_FFFF, 1,
        56'h0000FFFFFFFFFF, 1},
      '{4'd9, REQ_REINDEX, 4'd0, 4'd0, 56'hFFFFEFFFFFFFFF, 64'h7, 1, '0, 0},
      '{4'd9, REQ_REINDEX, 4'd5, 4'd5, 56'h5A37FDFFFFF12E, 64'h8, 0, '0, 0},
      '{4'd9, REQ_CELL, 4'd15, 4'd15, 56'h0, 64'h9, 1, '0, 0},
      // Single-cell grid: source and target coincide.
      '{4'd1, REQ_CELL, 4'd0, 4'd0, ALL_EMPTY, 64'hA, 1, '0, 0},
      '{4'd1, REQ_REINDEX, 4'd0, 4'd0, ALL_EMPTY, 64'hB, 1, 56'h000000000000FF, 1},
      // Size zero behaves as one.
      '{4'd0, REQ_CELL, 4'd1, 4'd0, ALL_EMPTY, 64'hC, 1, '0, 0},
      '{4'd0, REQ_REINDEX, 4'd0, 4'd0, 56'hFFFFFFFFFFFFF0, 64'hD, 0, '0, 0},
      // Oversized setting behaves as the largest grid.
      '{4'd15, REQ_CELL, 4'd12, 4'd12, 56'hFEFFFFFFFFFFFF, 64'hE, 0, '0, 0},
      '{4'd15, REQ_CELL, 4'd13, 4'd0, ALL_EMPTY, 64'hF, 1, '0, 0},
      '{4'd15, REQ_REINDEX, 4'd0, 4'd0, ALL_EMPTY, 64'h10, 1, 56'hFFFFFFFFFFFFFF, 1}
    };
    snd_idle_pct = 19;
    rcv_idle_pct = 58;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed requests, reprogramming the grid size whenever it changes.
    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].grid != grid_cfg) program_grid(plan[i].grid);
      send_request(plan[i].kind, plan[i].col, plan[i].row, plan[i].word, plan[i].wt,
                   plan[i].typed, plan[i].exp_word, plan[i].exp_keep);
    end

    // Random phases: slow receiver, then slow sender, then full rate.
    for (int ph = 0; ph < PHASES; ph++) begin
      program_grid(PHASE_GRIDS[ph]);
      if (ph < 3) begin
        snd_idle_pct = 19;
        rcv_idle_pct = 58;
      end else if (ph < 6) begin
        snd_idle_pct = 58;
        rcv_idle_pct = 19;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      repeat (PHASE_REQS) send_random_item();
    end

    settle_results();
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_successors.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
